### design/hfrc_pkg.sv
// Shared types, constants and helper functions of the hex frame receiver.
package hfrc_pkg;

    localparam int MAX_BYTES   = 128;
    localparam int HDR_BYTES   = 9;
    localparam int TAIL_BYTES  = 4;
    localparam int MIN_FRAME   = 13;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;
    localparam int FIFO_DEPTH  = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_OWN_ID        = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPORT_ACTIVE = 8'd1;

    localparam logic [7:0]  HEAD_0        = 8'hA5;
    localparam logic [7:0]  HEAD_1        = 8'hB6;
    localparam logic [7:0]  PROTO_VERSION = 8'h02;
    localparam logic [15:0] CRC_POLY      = 16'hA001;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] BROADCAST_ID  = 16'hFFFF;
    localparam logic [15:0] CMD_STOP      = 16'h0303;
    localparam logic [15:0] CMD_DISCOVER  = 16'hFFFF;
    localparam logic [7:0]  TYPE_DISCOVER = 8'h05;
    localparam logic [7:0]  TYPE_COMMAND  = 8'h01;
    localparam logic [15:0] OWN_ID_RESET  = 16'h0001;

    typedef enum logic [3:0] {
        VERDICT_BAD_HEX     = 4'd0,
        VERDICT_FOREIGN_ID  = 4'd1,
        VERDICT_BUSY        = 4'd2,
        VERDICT_BAD_FRAME   = 4'd3,
        VERDICT_BAD_VERSION = 4'd4,
        VERDICT_BAD_CRC     = 4'd5,
        VERDICT_HEARTBEAT   = 4'd6,
        VERDICT_NOT_COMMAND = 4'd7,
        VERDICT_ACCEPT      = 4'd8
    } verdict_t;

    typedef logic [HDR_BYTES-1:0][7:0]  hdr_bytes_t;
    typedef logic [TAIL_BYTES-1:0][7:0] tail_bytes_t;

    typedef struct packed {
        logic        fault;
        logic [7:0]  count;
        hdr_bytes_t  hdr;
        tail_bytes_t recent;
        logic [15:0] crc_snap;
    } line_sum_t;

    // {valid, value} of one ASCII hex digit
    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
            r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h41 && c <= 8'h46)
            r = {1'b1, 4'(c - 8'h37)};
        return r;
    endfunction

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

### design/hex_frame_receiver_checker_top.sv
// Top level of the hex frame receiver: config registers, front end, queue, verdict stage.
//
//   channel   handshake            payload
//   -------   ------------------   ---------------------------------------------------
//   input     push / full          character, line_end
//   result    pop / empty          verdict, frame_type, command_code, payload_length,
//                                  target_id
//   config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One character per cycle if not full; front end's byte-wide CRC step is combinational.
// After line_end, a verdict is readied via the summary queue, then the result register.
// full rises only when the two-entry summary queue is full behind a stalled result.
// Reset clears line state; own_id resets to 1, report_active to 0.
module hex_frame_receiver_checker_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [7:0]                          character,
    input  logic                                line_end,
    output logic                                empty,
    input  logic                                pop,
    output logic [3:0]                          verdict,
    output logic [7:0]                          frame_type,
    output logic [15:0]                         command_code,
    output logic [7:0]                          payload_length,
    output logic [15:0]                         target_id,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [hfrc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [hfrc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic [15:0]          own_id_reg, own_id_next;
    logic                 report_reg, report_next;
    logic                 take;
    logic                 sum_push;
    logic                 sum_pop;
    logic                 sum_empty;
    hfrc_pkg::line_sum_t  sum_wr;
    hfrc_pkg::line_sum_t  sum_rd;

    assign cfg_ready = 1'b1;
    assign take      = push && !full;

    always_comb
    begin
        own_id_next = own_id_reg;
        report_next = report_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                hfrc_pkg::CFG_OWN_ID:        own_id_next = cfg_data[15:0];
                hfrc_pkg::CFG_REPORT_ACTIVE: report_next = cfg_data[0];
                default:                     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_id_reg <= hfrc_pkg::OWN_ID_RESET;
            report_reg <= 1'b0;
        end
        else
        begin
            own_id_reg <= own_id_next;
            report_reg <= report_next;
        end
    end

    hfrc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .character (character),
        .line_end  (line_end),
        .sum_push  (sum_push),
        .sum_data  (sum_wr)
    );

    hfrc_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (sum_push),
        .wr_data (sum_wr),
        .full    (full),
        .pop     (sum_pop),
        .rd_data (sum_rd),
        .empty   (sum_empty)
    );

    hfrc_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .own_id         (own_id_reg),
        .report_active  (report_reg),
        .sum_empty      (sum_empty),
        .sum_data       (sum_rd),
        .sum_pop        (sum_pop),
        .empty          (empty),
        .pop            (pop),
        .verdict        (verdict),
        .frame_type     (frame_type),
        .command_code   (command_code),
        .payload_length (payload_length),
        .target_id      (target_id)
    );

endmodule

### design/hfrc_front.sv
// Character front end: nibble pairing, header capture, CRC and line summary.
module hfrc_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               take,
    input  logic [7:0]         character,
    input  logic               line_end,
    output logic               sum_push,
    output hfrc_pkg::line_sum_t sum_data
);

    logic                   pending_reg, pending_next;
    logic [3:0]             high_reg, high_next;
    logic [7:0]             count_reg, count_next;
    logic                   fault_reg, fault_next;
    hfrc_pkg::hdr_bytes_t   hdr_reg, hdr_next;
    hfrc_pkg::tail_bytes_t  recent_reg, recent_next;
    logic [15:0]            crc_reg, crc_next;
    logic [15:0]            snap_reg, snap_next;

    logic [4:0]  nib;
    logic [7:0]  byte_val;
    logic [7:0]  count_inc;
    logic [15:0] crc_new;
    logic [8:0]  snap_at;

    assign nib       = hfrc_pkg::nibble_of(character);
    assign byte_val  = {high_reg, nib[3:0]};
    assign count_inc = count_reg + 8'd1;
    assign crc_new   = hfrc_pkg::crc_byte(crc_reg, byte_val);
    assign snap_at   = 9'(hfrc_pkg::HDR_BYTES) + {1'b0, hdr_reg[7]};

    always_comb
    begin
        pending_next = pending_reg;
        high_next    = high_reg;
        count_next   = count_reg;
        fault_next   = fault_reg;
        hdr_next     = hdr_reg;
        recent_next  = recent_reg;
        crc_next     = crc_reg;
        snap_next    = snap_reg;
        if (take)
        begin
            if (line_end)
            begin
                pending_next = 1'b0;
                high_next    = 4'd0;
                count_next   = 8'd0;
                fault_next   = 1'b0;
                hdr_next     = '0;
                recent_next  = '0;
                crc_next     = hfrc_pkg::CRC_INIT;
                snap_next    = hfrc_pkg::CRC_INIT;
            end
            else if (!fault_reg)
            begin
                if (!nib[4])
                    fault_next = 1'b1;
                else if (!pending_reg)
                begin
                    high_next    = nib[3:0];
                    pending_next = 1'b1;
                end
                else
                begin
                    pending_next = 1'b0;
                    if (count_reg >= 8'(hfrc_pkg::MAX_BYTES))
                        fault_next = 1'b1;
                    else
                    begin
                        if (count_reg < 8'(hfrc_pkg::HDR_BYTES))
                            hdr_next[count_reg[3:0]] = byte_val;
                        recent_next = {byte_val, recent_reg[hfrc_pkg::TAIL_BYTES-1:1]};
                        crc_next    = crc_new;
                        count_next  = count_inc;
                        if (count_inc >= 8'(hfrc_pkg::HDR_BYTES) && {1'b0, count_inc} == snap_at)
                            snap_next = crc_new;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
            high_reg    <= 4'd0;
            count_reg   <= 8'd0;
            fault_reg   <= 1'b0;
            hdr_reg     <= '0;
            recent_reg  <= '0;
            crc_reg     <= hfrc_pkg::CRC_INIT;
            snap_reg    <= hfrc_pkg::CRC_INIT;
        end
        else
        begin
            pending_reg <= pending_next;
            high_reg    <= high_next;
            count_reg   <= count_next;
            fault_reg   <= fault_next;
            hdr_reg     <= hdr_next;
            recent_reg  <= recent_next;
            crc_reg     <= crc_next;
            snap_reg    <= snap_next;
        end
    end

    assign sum_push          = take && line_end;
    assign sum_data.fault    = fault_reg || pending_reg;
    assign sum_data.count    = count_reg;
    assign sum_data.hdr      = hdr_reg;
    assign sum_data.recent   = recent_reg;
    assign sum_data.crc_snap = snap_reg;

endmodule

### design/hfrc_fifo.sv
// Short queue of line summaries between front end and verdict stage.
module hfrc_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  hfrc_pkg::line_sum_t wr_data,
    output logic                full,
    input  logic                pop,
    output hfrc_pkg::line_sum_t rd_data,
    output logic                empty
);

    localparam int PTR_W = $clog2(hfrc_pkg::FIFO_DEPTH);
    localparam int CNT_W = $clog2(hfrc_pkg::FIFO_DEPTH + 1);

    hfrc_pkg::line_sum_t mem_reg [hfrc_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = cnt_reg == CNT_W'(hfrc_pkg::FIFO_DEPTH);
    assign empty   = cnt_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(hfrc_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(hfrc_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

### design/hfrc_back.sv
// Verdict stage: judges one line summary and holds the result for the consumer.
module hfrc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [15:0]         own_id,
    input  logic                report_active,
    input  logic                sum_empty,
    input  hfrc_pkg::line_sum_t sum_data,
    output logic                sum_pop,
    output logic                empty,
    input  logic                pop,
    output logic [3:0]          verdict,
    output logic [7:0]          frame_type,
    output logic [15:0]         command_code,
    output logic [7:0]          payload_length,
    output logic [15:0]         target_id
);

    logic                valid_reg, valid_next;
    hfrc_pkg::verdict_t  verdict_reg, verdict_next;
    logic [7:0]          type_reg, type_next;
    logic [15:0]         cmd_reg, cmd_next;
    logic [7:0]          len_reg, len_next;
    logic [15:0]         id_reg, id_next;

    logic        head_ok;
    logic        tail_ok;
    logic [15:0] id;
    logic [15:0] cmd;
    logic [15:0] rx_crc;
    logic [8:0]  frame_len;
    hfrc_pkg::verdict_t judged;

    assign sum_pop   = !sum_empty && (!valid_reg || pop);
    assign head_ok   = sum_data.hdr[0] == hfrc_pkg::HEAD_0 && sum_data.hdr[1] == hfrc_pkg::HEAD_1;
    assign tail_ok   = sum_data.recent[2] == hfrc_pkg::HEAD_1
                    && sum_data.recent[3] == hfrc_pkg::HEAD_0;
    assign id        = {sum_data.hdr[2], sum_data.hdr[3]};
    assign cmd       = {sum_data.hdr[5], sum_data.hdr[6]};
    assign rx_crc    = {sum_data.recent[0], sum_data.recent[1]};
    assign frame_len = 9'(hfrc_pkg::MIN_FRAME) + {1'b0, sum_data.hdr[7]};

    always_comb
    begin
        if (sum_data.fault)
            judged = hfrc_pkg::VERDICT_BAD_HEX;
        else if (sum_data.count >= 8'd4 && head_ok && id != own_id
                 && id != hfrc_pkg::BROADCAST_ID)
            judged = hfrc_pkg::VERDICT_FOREIGN_ID;
        else if (report_active && sum_data.count >= 8'd7 && cmd != hfrc_pkg::CMD_STOP)
            judged = hfrc_pkg::VERDICT_BUSY;
        else if (sum_data.count < 8'(hfrc_pkg::MIN_FRAME) || !head_ok
                 || {1'b0, sum_data.count} != frame_len || !tail_ok)
            judged = hfrc_pkg::VERDICT_BAD_FRAME;
        else if (sum_data.hdr[8] != hfrc_pkg::PROTO_VERSION)
            judged = hfrc_pkg::VERDICT_BAD_VERSION;
        else if (rx_crc != sum_data.crc_snap)
            judged = hfrc_pkg::VERDICT_BAD_CRC;
        else if (sum_data.hdr[4] == hfrc_pkg::TYPE_DISCOVER && cmd == hfrc_pkg::CMD_DISCOVER)
            judged = hfrc_pkg::VERDICT_HEARTBEAT;
        else if (sum_data.hdr[4] != hfrc_pkg::TYPE_COMMAND)
            judged = hfrc_pkg::VERDICT_NOT_COMMAND;
        else
            judged = hfrc_pkg::VERDICT_ACCEPT;
    end

    always_comb
    begin
        valid_next   = valid_reg;
        verdict_next = verdict_reg;
        type_next    = type_reg;
        cmd_next     = cmd_reg;
        len_next     = len_reg;
        id_next      = id_reg;
        if (pop && valid_reg)
            valid_next = 1'b0;
        if (sum_pop)
        begin
            valid_next   = 1'b1;
            verdict_next = judged;
            type_next    = sum_data.hdr[4];
            cmd_next     = cmd;
            len_next     = sum_data.hdr[7];
            id_next      = id;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        verdict_reg <= verdict_next;
        type_reg    <= type_next;
        cmd_reg     <= cmd_next;
        len_reg     <= len_next;
        id_reg      <= id_next;
    end

    assign empty          = !valid_reg;
    assign verdict        = verdict_reg;
    assign frame_type     = type_reg;
    assign command_code   = cmd_reg;
    assign payload_length = len_reg;
    assign target_id      = id_reg;

endmodule

### sim/hex_frame_receiver_checker_top_test.sv
// Self-checking test of the hex frame receiver: line stimulus, verdict predictor and scoreboard.
module hex_frame_receiver_checker_top_test;

    import hfrc_pkg::*;

    typedef struct {
        verdict_t    verdict;
        logic [7:0]  ftype;
        logic [15:0] opcode;
        logic [7:0]  len;
        logic [15:0] dest;
    } verdict_rec_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   push = 1'b0;
    logic                   full;
    logic [7:0]             character = 8'h00;
    logic                   line_end = 1'b0;
    logic                   empty;
    logic                   pop = 1'b0;
    logic [3:0]             verdict;
    logic [7:0]             frame_type;
    logic [15:0]            command_code;
    logic [7:0]             payload_length;
    logic [15:0]            target_id;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    hex_frame_receiver_checker_top u_top (.*);

    always #6 clk = ~clk;

    // predictor state
    logic [15:0] model_own_id;
    logic        model_reporting;
    logic        half_byte;
    logic [3:0]  upper_nibble;
    int unsigned byte_total;
    logic        hex_fault;
    logic [7:0]  head_q [HDR_BYTES];
    logic [15:0] crc_run;
    logic [15:0] crc_mark;
    logic [7:0]  last_q [TAIL_BYTES];

    verdict_rec_t expected_verdicts [$];
    logic [7:0]   line_buf [$];

    int send_idle_pct = 0;
    int pop_stall_pct = 0;
    int pop_hold = 0;
    int mismatch_count = 0;
    int item_count = 0;
    int line_count = 0;
    int stall_count = 0;
    int checked_count = 0;
    int verdict_hits [9];

    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] acc;
        acc = crc ^ {8'h00, b};
        repeat (8)
        begin
            acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
        end
        return acc;
    endfunction

    function automatic int hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return int'(c - "0");
        if (c >= "A" && c <= "F")
            return int'(c - "A") + 10;
        return -1;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        return (n < 4'd10) ? (8'h30 + n) : (8'h37 + n);
    endfunction

    function automatic void clear_line_state();
        half_byte = 1'b0;
        upper_nibble = 4'h0;
        byte_total = 0;
        hex_fault = 1'b0;
        foreach (head_q[i])
            head_q[i] = 8'h00;
        foreach (last_q[i])
            last_q[i] = 8'h00;
        crc_run = CRC_INIT;
        crc_mark = CRC_INIT;
    endfunction

    function automatic void absorb_byte(input logic [7:0] b);
        if (byte_total >= MAX_BYTES)
        begin
            hex_fault = 1'b1;
            return;
        end
        if (byte_total < HDR_BYTES)
            head_q[byte_total] = b;
        for (int i = 0; i < TAIL_BYTES - 1; i++)
            last_q[i] = last_q[i + 1];
        last_q[TAIL_BYTES - 1] = b;
        crc_run = crc16_step(crc_run, b);
        byte_total++;
        if (byte_total >= HDR_BYTES && byte_total == HDR_BYTES + head_q[7])
            crc_mark = crc_run;
    endfunction

    function automatic verdict_t frame_verdict();
        logic        head_ok;
        logic [15:0] dest;
        logic [15:0] opcode;
        head_ok = (head_q[0] == HEAD_0) && (head_q[1] == HEAD_1);
        dest = {head_q[2], head_q[3]};
        opcode = {head_q[5], head_q[6]};
        if (hex_fault || half_byte)
            return VERDICT_BAD_HEX;
        if (byte_total >= 4 && head_ok && dest != model_own_id && dest != BROADCAST_ID)
            return VERDICT_FOREIGN_ID;
        if (model_reporting && byte_total >= 7 && opcode != CMD_STOP)
            return VERDICT_BUSY;
        if (byte_total < MIN_FRAME || !head_ok || byte_total != MIN_FRAME + head_q[7])
            return VERDICT_BAD_FRAME;
        if (last_q[2] != HEAD_1 || last_q[3] != HEAD_0)
            return VERDICT_BAD_FRAME;
        if (head_q[8] != PROTO_VERSION)
            return VERDICT_BAD_VERSION;
        if ({last_q[0], last_q[1]} != crc_mark)
            return VERDICT_BAD_CRC;
        if (head_q[4] == TYPE_DISCOVER && opcode == CMD_DISCOVER)
            return VERDICT_HEARTBEAT;
        if (head_q[4] != TYPE_COMMAND)
            return VERDICT_NOT_COMMAND;
        return VERDICT_ACCEPT;
    endfunction

    function automatic void model_item(input logic [7:0] c, input logic le);
        verdict_rec_t rec;
        int           d;
        if (le)
        begin
            rec.verdict = frame_verdict();
            rec.ftype = head_q[4];
            rec.opcode = {head_q[5], head_q[6]};
            rec.len = head_q[7];
            rec.dest = {head_q[2], head_q[3]};
            expected_verdicts.push_back(rec);
            clear_line_state();
        end
        else if (!hex_fault)
        begin
            d = hex_digit(c);
            if (d < 0)
                hex_fault = 1'b1;
            else if (!half_byte)
            begin
                upper_nibble = d[3:0];
                half_byte = 1'b1;
            end
            else
            begin
                half_byte = 1'b0;
                absorb_byte({upper_nibble, d[3:0]});
            end
        end
    endfunction

    task automatic compare_field(input string what, input logic [15:0] want, input logic [15:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            $display("%0t %s mismatch: expected %0h actual %0h", $time, what, want, got);
        end
    endtask

    task automatic take_result();
        verdict_rec_t want;
        if (expected_verdicts.size() == 0)
        begin
            mismatch_count++;
            $display("%0t unexpected result: expected none, actual verdict %0d", $time, verdict);
        end
        else
        begin
            want = expected_verdicts.pop_front();
            verdict_hits[int'(want.verdict)]++;
            checked_count++;
            compare_field("verdict", want.verdict, verdict);
            compare_field("frame_type", want.ftype, frame_type);
            compare_field("command_code", want.opcode, command_code);
            compare_field("payload_length", want.len, payload_length);
            compare_field("target_id", want.dest, target_id);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            take_result();
        if (pop_hold > 0)
        begin
            pop <= 1'b0;
            pop_hold--;
        end
        else
            pop <= ($urandom_range(99) >= pop_stall_pct);
    end

    task automatic send_item(input logic [7:0] ch, input logic le);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        character <= ch;
        line_end <= le;
        @(posedge clk);
        while (full)
        begin
            stall_count++;
            @(posedge clk);
        end
        model_item(ch, le);
        item_count++;
    endtask

    task automatic send_line();
        foreach (line_buf[i])
            send_item(line_buf[i], 1'b0);
        send_item(8'($urandom), 1'b1);
        line_buf.delete();
        line_count++;
    endtask

    function automatic void put_byte(input logic [7:0] b);
        line_buf.push_back(hex_char(b[7:4]));
        line_buf.push_back(hex_char(b[3:0]));
    endfunction

    function automatic void build_frame(input logic [15:0] dest, input logic [7:0] ftype,
                                        input logic [15:0] opcode, input logic [7:0] len_field,
                                        input int pay_count, input logic [7:0] ver,
                                        input logic [15:0] crc_flip);
        logic [7:0]  fb [$];
        logic [15:0] crc;
        fb = '{HEAD_0, HEAD_1, dest[15:8], dest[7:0], ftype, opcode[15:8], opcode[7:0],
               len_field, ver};
        repeat (pay_count)
            fb.push_back(8'($urandom));
        crc = CRC_INIT;
        foreach (fb[i])
            crc = crc16_step(crc, fb[i]);
        crc = crc ^ crc_flip;
        fb.push_back(crc[15:8]);
        fb.push_back(crc[7:0]);
        fb.push_back(HEAD_1);
        fb.push_back(HEAD_0);
        foreach (fb[i])
            put_byte(fb[i]);
    endfunction

    task automatic quiesce();
        push <= 1'b0;
        while (expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        quiesce();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_OWN_ID)
            model_own_id = data;
        else if (idx == CFG_REPORT_ACTIVE)
            model_reporting = data[0];
    endtask

    task automatic test_directed_verdicts();
        build_frame(OWN_ID_RESET, TYPE_COMMAND, 16'h0102, 8'd0, 0, PROTO_VERSION, 16'h0000);
        send_line();
        build_frame(BROADCAST_ID, TYPE_COMMAND, 16'hA55A, 8'd3, 3, PROTO_VERSION, 16'h0000);
        send_line();
        build_frame(16'h1234, TYPE_COMMAND, 16'h0102, 8'd1, 1, PROTO_VERSION, 16'h0000);
        send_line();
        // foreign id on a four byte line
        put_byte(HEAD_0);
        put_byte(HEAD_1);
        put_byte(8'h00);
        put_byte(8'h00);
        send_line();
        send_line();
        build_frame(OWN_ID_RESET, TYPE_DISCOVER, CMD_DISCOVER, 8'd0, 0, PROTO_VERSION, 16'h0000);
        send_line();
        build_frame(OWN_ID_RESET, TYPE_DISCOVER, 16'h0001, 8'd2, 2, PROTO_VERSION, 16'h0000);
        send_line();
        build_frame(OWN_ID_RESET, 8'hFF, 16'hFFFF, 8'd1, 1, PROTO_VERSION, 16'h0000);
        send_line();
        build_frame(OWN_ID_RESET, TYPE_COMMAND, 16'h0102, 8'd0, 0, 8'h03, 16'h0000);
        send_line();
        build_frame(OWN_ID_RESET, TYPE_COMMAND, 16'h0102, 8'd2, 2, PROTO_VERSION, 16'h0001);
        send_line();
        build_frame(OWN_ID_RESET, TYPE_COMMAND, 16'h0102, 8'd0, 0, PROTO_VERSION, 16'h8000);
        send_line();
        // corrupt the tail
        build_frame(OWN_ID_RESET, TYPE_COMMAND, 16'h0102, 8'd0, 0, PROTO_VERSION, 16'h0000);
        line_buf[line_buf.size() - 1] = "4";
        send_line();
        build_frame(OWN_ID_RESET, TYPE_COMMAND, 16'h0102, 8'd5, 4, PROTO_VERSION, 16'h0000);
        send_line();
        put_byte(HEAD_0);
        put_byte(HEAD_1);
        put_byte(8'h00);
        put_byte(8'h01);
        put_byte(TYPE_COMMAND);
        send_line();
        // corrupt the head
        build_frame(OWN_ID_RESET, TYPE_COMMAND, 16'h0102, 8'd0, 0, PROTO_VERSION, 16'h0000);
        line_buf[3] = "7";
        send_line();
        build_frame(OWN_ID_RESET, TYPE_COMMAND, 16'h0102, 8'd0, 0, PROTO_VERSION, 16'h0000);
        line_buf[4] = "a";
        send_line();
        build_frame(OWN_ID_RESET, TYPE_COMMAND, 16'h0102, 8'd0, 0, PROTO_VERSION, 16'h0000);
        line_buf.pop_back();
        send_line();
        // drop everything after a bad character
        line_buf.push_back("G");
        build_frame(OWN_ID_RESET, TYPE_COMMAND, 16'h0102, 8'd0, 0, PROTO_VERSION, 16'h0000);
        send_line();
        line_buf.push_back(8'h00);
        send_line();
        line_buf.push_back(8'hFF);
        send_line();
        build_frame(OWN_ID_RESET, TYPE_COMMAND, 16'hFFFF, 8'(MAX_BYTES - MIN_FRAME),
                    MAX_BYTES - MIN_FRAME, PROTO_VERSION, 16'h0000);
        send_line();
        build_frame(OWN_ID_RESET, TYPE_COMMAND, 16'h0000, 8'(MAX_BYTES - MIN_FRAME + 1),
                    MAX_BYTES - MIN_FRAME + 1, PROTO_VERSION, 16'h0000);
        send_line();
    endtask

    task automatic test_report_busy();
        write_reg(CFG_REPORT_ACTIVE, 16'h0001);
        build_frame(OWN_ID_RESET, TYPE_COMMAND, CMD_STOP, 8'd1, 1, PROTO_VERSION, 16'h0000);
        send_line();
        build_frame(OWN_ID_RESET, TYPE_COMMAND, 16'h0102, 8'd1, 1, PROTO_VERSION, 16'h0000);
        send_line();
        build_frame(16'h2222, TYPE_COMMAND, 16'h0102, 8'd0, 0, PROTO_VERSION, 16'h0000);
        send_line();
        build_frame(BROADCAST_ID, TYPE_DISCOVER, CMD_DISCOVER, 8'd0, 0, PROTO_VERSION, 16'h0000);
        send_line();
        // six bytes escape the busy check, seven do not
        build_frame(OWN_ID_RESET, TYPE_COMMAND, 16'h0102, 8'd0, 0, PROTO_VERSION, 16'h0000);
        repeat (line_buf.size() - 12)
            line_buf.pop_back();
        send_line();
        build_frame(OWN_ID_RESET, TYPE_COMMAND, 16'h0102, 8'd0, 0, PROTO_VERSION, 16'h0000);
        repeat (line_buf.size() - 14)
            line_buf.pop_back();
        send_line();
        build_frame(OWN_ID_RESET, TYPE_COMMAND, 16'h0102, 8'd0, 0, PROTO_VERSION, 16'h0000);
        line_buf.pop_back();
        send_line();
        // only bit 0 of the data counts
        write_reg(CFG_REPORT_ACTIVE, {15'($urandom), 1'b0});
    endtask

    task automatic test_own_id_extremes();
        write_reg(CFG_OWN_ID, 16'h0000);
        build_frame(16'h0000, TYPE_COMMAND, 16'h0102, 8'd0, 0, PROTO_VERSION, 16'h0000);
        send_line();
        build_frame(OWN_ID_RESET, TYPE_COMMAND, 16'h0102, 8'd0, 0, PROTO_VERSION, 16'h0000);
        send_line();
        build_frame(BROADCAST_ID, TYPE_COMMAND, 16'h0102, 8'd0, 0, PROTO_VERSION, 16'h0000);
        send_line();
        write_reg(CFG_OWN_ID, 16'hFFFF);
        build_frame(16'hFFFF, TYPE_COMMAND, 16'h0102, 8'd0, 0, PROTO_VERSION, 16'h0000);
        send_line();
        build_frame(16'h0000, TYPE_COMMAND, 16'h0102, 8'd0, 0, PROTO_VERSION, 16'h0000);
        send_line();
        write_reg(CFG_OWN_ID, 16'hFFFE);
        build_frame(16'hFFFE, TYPE_COMMAND, 16'h0102, 8'd0, 0, PROTO_VERSION, 16'h0000);
        send_line();
    endtask

    task automatic test_full_backpressure();
        quiesce();
        // hold the result side off while requests keep coming
        pop_hold = 300;
        repeat (10)
            send_line();
        build_frame(model_own_id, TYPE_COMMAND, 16'h0102, 8'd0, 0, PROTO_VERSION, 16'h0000);
        send_line();
        repeat (5)
            send_line();
        quiesce();
    endtask

    task automatic random_line();
        int          kind;
        int          len;
        int          pos;
        int          keep;
        logic [15:0] dest;
        logic [15:0] opcode;
        logic [7:0]  ftype;
        logic [7:0]  ver;
        kind = $urandom_range(99);
        case ($urandom_range(9))
            0, 1, 2, 3, 4: dest = model_own_id;
            5, 6:          dest = BROADCAST_ID;
            default:       dest = 16'($urandom);
        endcase
        case ($urandom_range(9))
            0, 1:    opcode = CMD_STOP;
            2, 3:    opcode = CMD_DISCOVER;
            default: opcode = 16'($urandom);
        endcase
        case ($urandom_range(9))
            0, 1:    ftype = TYPE_DISCOVER;
            2:       ftype = 8'($urandom);
            default: ftype = TYPE_COMMAND;
        endcase
        len = ($urandom_range(19) == 0) ? $urandom_range(MAX_BYTES - MIN_FRAME, 20)
                                        : $urandom_range(6);
        ver = ($urandom_range(11) == 0) ? 8'($urandom) : PROTO_VERSION;
        if (kind < 85)
        begin
            build_frame(dest, ftype, opcode, 8'(len), ($urandom_range(19) == 0) ? len + 1 : len,
                        ver, ($urandom_range(19) == 0) ? 16'($urandom_range(65535, 1)) : 16'h0000);
            pos = $urandom_range(line_buf.size() - 1);
            if (kind >= 60 && kind < 68)
                line_buf[pos] = 8'($urandom);
            else if (kind >= 68 && kind < 76)
                line_buf.delete(pos);
            else if (kind >= 76)
            begin
                keep = 2 * $urandom_range(line_buf.size() / 2 - 1);
                while (line_buf.size() > keep)
                    line_buf.pop_back();
            end
        end
        else if (kind < 92)
        begin
            if ($urandom_range(1))
            begin
                put_byte(HEAD_0);
                put_byte(HEAD_1);
            end
            repeat ($urandom_range(16))
                put_byte(8'($urandom));
        end
        else if (kind >= 96)
        begin
            repeat ($urandom_range(MAX_BYTES + 3, MAX_BYTES - 1))
                put_byte(8'($urandom));
        end
        send_line();
    endtask

    task automatic test_random_lines();
        int send_modes [4];
        int pop_modes [4];
        int start_items;
        int start_lines;
        send_modes = '{0, 76, 0, 23};
        pop_modes = '{0, 0, 76, 23};
        for (int p = 0; p < 4; p++)
        begin
            case ($urandom_range(3))
                0:       write_reg(CFG_OWN_ID, 16'h0000);
                1:       write_reg(CFG_OWN_ID, 16'hFFFF);
                2:       write_reg(CFG_OWN_ID, OWN_ID_RESET);
                default: write_reg(CFG_OWN_ID, 16'($urandom));
            endcase
            write_reg(CFG_REPORT_ACTIVE, ($urandom_range(3) == 0) ? 16'h0001 : 16'h0000);
            send_idle_pct = send_modes[p];
            pop_stall_pct = pop_modes[p];
            start_items = item_count;
            start_lines = line_count;
            while (item_count - start_items < 40 || line_count - start_lines < 2)
                random_line();
            quiesce();
        end
        send_idle_pct = 0;
        pop_stall_pct = 0;
    endtask

    initial
    begin
        int kinds_hit;
        model_own_id = OWN_ID_RESET;
        model_reporting = 1'b0;
        clear_line_state();
        foreach (verdict_hits[i])
            verdict_hits[i] = 0;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_verdicts();
        test_report_busy();
        test_own_id_extremes();
        test_full_backpressure();
        test_random_lines();
        quiesce();
        kinds_hit = 0;
        foreach (verdict_hits[i])
            if (verdict_hits[i] > 0)
                kinds_hit++;
        $display("Sent %0d input requests in %0d lines; checked %0d verdicts, %0d of 9 kinds seen.",
                 item_count, line_count, checked_count, kinds_hit);
        $display("Input stalled by full on %0d cycles; own_id and report_active swept to extremes.",
                 stall_count);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #(12 * 600000);
        $display("Timeout with %0d verdicts outstanding", expected_verdicts.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
